// ----- rtl/psaq_pkg.sv -----
// ---------------------------------------------------------------------------
// psaq_pkg: shared types and constants for the point store annulus query.
// Holds the point and result records and the operation codes.
// ---------------------------------------------------------------------------
`default_nettype none

package psaq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned SQ_W         = 34;
  localparam int unsigned D2_W         = 35;
  localparam int unsigned R2_W         = 32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [COORD_W-1:0] heading;
  } point_t;

  // One point on its way through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             match;
    logic [IDX_W-1:0] index;
    point_t           pt;
  } probe_t;

  typedef struct packed {
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [COORD_W-1:0]        point_heading;
    logic                      match_valid;
    logic                      status;
    logic                      last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/psaq_if.sv -----
// ---------------------------------------------------------------------------
// psaq channel interfaces
// Request and result channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface psaq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        heading;
  logic [15:0]        min_dist;
  logic [15:0]        max_dist;

  modport source (output valid, op, pos_x, pos_y, pos_z, heading, min_dist, max_dist,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, heading, min_dist, max_dist,
                  output ready);
endinterface

interface psaq_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         point_index;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic [15:0]        point_heading;
  logic               match_valid;
  logic               status;
  logic               last;

  modport source (output valid, point_index, point_x, point_y, point_z, point_heading,
                  match_valid, status, last, input ready);
  modport sink   (input valid, point_index, point_x, point_y, point_z, point_heading,
                  match_valid, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/point_store_annulus_query.sv -----
// ---------------------------------------------------------------------------
// point_store_annulus_query: point store with distance band search
// Stores up to CAPACITY points in a rotating chain of cells and answers
// add, clear and find requests on a valid/ready result channel.
// ---------------------------------------------------------------------------
//
//   channel  | dir | contents
//   ---------+-----+--------------------------------------------------
//   in_ch    | in  | op, pos_x/y/z, heading, min_dist, max_dist
//   out_ch   | out | point_index, point_x/y/z, point_heading,
//            |     | match_valid, status, last
//
// An add or clear transaction presents its result in the cycle after acceptance.
// A find rotates the cell chain once around, feeding the head cell into a
// two-stage distance pipeline, then passes through the drain and finish
// states to empty the pipeline and close with a last result.
// Reset (synchronous, active high) empties the store; no clearing pass runs.
// A stalled result channel freezes the chain and the pipeline, so no
// transaction is lost however long the stall lasts.
`default_nettype none

module point_store_annulus_query
  import psaq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst,
  psaq_in_if.sink    in_ch,
  psaq_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [SW-1:0]   step;
  logic [1:0]      drain_cnt;
  point_t          query;
  logic [R2_W-1:0] mn2, mx2;
  result_t         out_reg;
  logic            out_valid;
  logic            pend_v;
  probe_t          pend;

  // The output slot can take a new transaction this cycle.
  logic out_free;
  assign out_free = !out_valid || out_ch.ready;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;

  op_t in_op;
  assign in_op = op_t'(in_ch.op);

  logic add_ok;
  assign add_ok = accept && (in_op == OP_ADD) && (count < CW'(CAPACITY));

  logic adv, shift;
  assign adv   = out_free;
  assign shift = (state == ST_SCAN) && adv;

  point_t new_pt;
  assign new_pt = '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z, heading: in_ch.heading};

  // Rotating chain: cell k takes cell k+1, the last cell takes the head.
  point_t cells [CAPACITY];
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    psaq_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .nb    (cells[(k + 1) % CAPACITY]),
      .we    (add_ok && (count == CW'(k))),
      .wd    (new_pt),
      .q     (cells[k])
    );
  end

  probe_t issue, res;
  always_comb begin
    issue.valid = (state == ST_SCAN) && (CW'(step) < count);
    issue.match = 1'b0;
    issue.index = IDX_W'(step);
    issue.pt    = cells[0];
  end

  psaq_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .issue (issue),
    .query (query),
    .mn2   (mn2),
    .mx2   (mx2),
    .res   (res)
  );

  function automatic result_t match_result(probe_t p, logic lst);
    result_t r;
    r.point_index   = p.index;
    r.point_x       = p.pt.x;
    r.point_y       = p.pt.y;
    r.point_z       = p.pt.z;
    r.point_heading = p.pt.heading;
    r.match_valid   = 1'b1;
    r.status        = 1'b0;
    r.last          = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      step      <= '0;
      drain_cnt <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            out_reg <= '0;
            case (in_op)
              OP_ADD: begin
                out_valid    <= 1'b1;
                out_reg.last <= 1'b1;
                if (add_ok) begin
                  out_reg.point_index <= IDX_W'(count);
                  count               <= count + 1'b1;
                end else begin
                  out_reg.status <= 1'b1;
                end
              end
              OP_CLEAR: begin
                out_valid    <= 1'b1;
                out_reg.last <= 1'b1;
                count        <= '0;
              end
              OP_FIND: begin
                query  <= new_pt;
                mn2    <= in_ch.min_dist * in_ch.min_dist;
                mx2    <= in_ch.max_dist * in_ch.max_dist;
                step   <= '0;
                pend_v <= 1'b0;
                state  <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN, ST_DRAIN, ST_FINISH: begin
          if (adv) begin
            // A new match pushes the previous one out, which is then not last.
            if (res.valid && res.match && (state != ST_FINISH)) begin
              pend   <= res;
              pend_v <= 1'b1;
              if (pend_v) begin
                out_reg   <= match_result(pend, 1'b0);
                out_valid <= 1'b1;
              end
            end
            if (state == ST_SCAN) begin
              step <= step + 1'b1;
              if (step == SW'(CAPACITY - 1)) begin
                state     <= ST_DRAIN;
                drain_cnt <= 2'd2;
              end
            end else if (state == ST_DRAIN) begin
              drain_cnt <= drain_cnt - 1'b1;
              if (drain_cnt == 2'd1) begin
                state <= ST_FINISH;
              end
            end else begin
              out_valid <= 1'b1;
              pend_v    <= 1'b0;
              state     <= ST_IDLE;
              if (pend_v) begin
                out_reg <= match_result(pend, 1'b1);
              end else begin
                out_reg      <= '0;
                out_reg.last <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.point_index   = out_reg.point_index;
  assign out_ch.point_x       = out_reg.point_x;
  assign out_ch.point_y       = out_reg.point_y;
  assign out_ch.point_z       = out_reg.point_z;
  assign out_ch.point_heading = out_reg.point_heading;
  assign out_ch.match_valid   = out_reg.match_valid;
  assign out_ch.status        = out_reg.status;
  assign out_ch.last          = out_reg.last;

endmodule

`default_nettype wire

// ----- rtl/psaq_cell.sv -----
// ---------------------------------------------------------------------------
// psaq_cell: one storage cell of the point chain
// Holds one point; loads a new point or takes its neighbor's on a shift.
// ---------------------------------------------------------------------------
`default_nettype none

module psaq_cell
  import psaq_pkg::*;
(
  input  wire         clk,
  input  wire         shift,
  input  wire point_t nb,
  input  wire         we,
  input  wire point_t wd,
  output point_t      q
);

  point_t pt;

  always_ff @(posedge clk) begin
    if (we) begin
      pt <= wd;
    end else if (shift) begin
      pt <= nb;
    end
  end

  assign q = pt;

endmodule

`default_nettype wire

// ----- rtl/psaq_dist.sv -----
// ---------------------------------------------------------------------------
// psaq_dist: two-stage squared distance and band test
// Stage A squares the axis differences, stage B sums and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module psaq_dist
  import psaq_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              adv,
  input  wire probe_t      issue,
  input  wire point_t      query,
  input  wire [R2_W-1:0]   mn2,
  input  wire [R2_W-1:0]   mx2,
  output probe_t           res
);

  probe_t          stage_a;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  probe_t          stage_b;

  logic signed [COORD_W:0]     dx, dy, dz;
  logic signed [2*COORD_W+1:0] prod_x, prod_y, prod_z;
  logic [SQ_W-1:0]             sq_x_next, sq_y_next, sq_z_next;
  logic [D2_W-1:0]             d2;

  always_comb begin
    dx = $signed({issue.pt.x[COORD_W-1], issue.pt.x}) - $signed({query.x[COORD_W-1], query.x});
    dy = $signed({issue.pt.y[COORD_W-1], issue.pt.y}) - $signed({query.y[COORD_W-1], query.y});
    dz = $signed({issue.pt.z[COORD_W-1], issue.pt.z}) - $signed({query.z[COORD_W-1], query.z});
    // Full-width signed products; a square is never negative.
    prod_x = dx * dx;
    prod_y = dy * dy;
    prod_z = dz * dz;
    sq_x_next = SQ_W'(unsigned'(prod_x));
    sq_y_next = SQ_W'(unsigned'(prod_y));
    sq_z_next = SQ_W'(unsigned'(prod_z));
    d2 = D2_W'(sq_x) + D2_W'(sq_y) + D2_W'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a.valid <= 1'b0;
      stage_b.valid <= 1'b0;
    end else if (adv) begin
      stage_a.valid <= issue.valid;
      stage_b.valid <= stage_a.valid;
    end
    if (adv) begin
      stage_a.match <= 1'b0;
      stage_a.index <= issue.index;
      stage_a.pt    <= issue.pt;
      sq_x          <= sq_x_next;
      sq_y          <= sq_y_next;
      sq_z          <= sq_z_next;
      stage_b.index <= stage_a.index;
      stage_b.pt    <= stage_a.pt;
      stage_b.match <= (d2 >= D2_W'(mn2)) && (d2 <= D2_W'(mx2)) && stage_a.valid;
    end
  end

  assign res = stage_b;

endmodule

`default_nettype wire

// ----- rtl/psaq_checker.sv -----
// ---------------------------------------------------------------------------
// psaq_checker: port-level checks for the point store annulus query
// Watches both channels and flags handshake and result-format slips.
// ---------------------------------------------------------------------------
`default_nettype none

module psaq_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [5:0]  out_index,
  input wire        out_match,
  input wire        out_status,
  input wire        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result slot is blocked");

  a_nomatch_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_match |-> out_last)
    else $error("non-match result not marked last");

  a_full_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_last && !out_match && (out_index == 6'd0))
    else $error("store-full result malformed");

endmodule

bind point_store_annulus_query psaq_checker u_psaq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_index  (out_ch.point_index),
  .out_match  (out_ch.match_valid),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

`default_nettype wire

// ----- dv/point_store_annulus_query_tb.sv -----
// ---------------------------------------------------------------------------
// point_store_annulus_query_tb: self-checking bench for the point store
// Drives add, clear and find transactions with random gaps, predicts every
// result from a private copy of the store and compares field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_store_annulus_query_tb;
  import psaq_pkg::*;

  localparam int CAP = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [15:0]        hd;
    logic [15:0]        rmin;
    logic [15:0]        rmax;
  } request_t;

  logic clk;
  logic rst;

  psaq_in_if  req_ch ();
  psaq_out_if res_ch ();

  point_store_annulus_query #(.CAPACITY(CAP)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  // Requests waiting for the driver, and results the monitor still expects.
  request_t pending_reqs[$];
  result_t  expected_results[$];

  // Predictor state: shadow copy of the store and its fill level.
  point_t model_store[CAP];
  int     model_count;

  int  error_count;
  int  idle_cycles;
  int  hold_off;
  bit  calm_mode;
  bit  stimulus_done;
  int  n_adds, n_finds, n_clears, n_matches, n_full;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Squared distance between a stored point and a query position; each
  // square fits in 32 bits, so 35 bits hold the sum.
  function automatic logic [34:0] dist_sq(point_t p, request_t r);
    longint dx, dy, dz;
    dx = longint'(p.x) - longint'(r.px);
    dy = longint'(p.y) - longint'(r.py);
    dz = longint'(p.z) - longint'(r.pz);
    return 35'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Works out the results of one accepted request and updates the shadow store.
  task automatic predict_request(request_t r);
    result_t res;
    int      hits;
    logic [34:0] d2, lo2, hi2;
    res = '0;
    res.last = 1'b1;
    case (r.op)
      OP_ADD: begin
        n_adds++;
        if (model_count < CAP) begin
          model_store[model_count] = '{x: r.px, y: r.py, z: r.pz, heading: r.hd};
          res.point_index = 6'(model_count);
          model_count++;
        end else begin
          res.status = 1'b1;
          n_full++;
        end
        expected_results.push_back(res);
      end
      OP_FIND: begin
        n_finds++;
        hits = 0;
        lo2 = 35'(r.rmin) * 35'(r.rmin);
        hi2 = 35'(r.rmax) * 35'(r.rmax);
        for (int i = 0; i < model_count; i++) begin
          d2 = dist_sq(model_store[i], r);
          if (d2 >= lo2 && d2 <= hi2) begin
            res = '0;
            res.point_index   = 6'(i);
            res.point_x       = model_store[i].x;
            res.point_y       = model_store[i].y;
            res.point_z       = model_store[i].z;
            res.point_heading = model_store[i].heading;
            res.match_valid   = 1'b1;
            expected_results.push_back(res);
            hits++;
          end
        end
        n_matches += hits;
        if (hits == 0) begin
          res = '0;
          res.last = 1'b1;
          expected_results.push_back(res);
        end else begin
          expected_results[$].last = 1'b1;
        end
      end
      OP_CLEAR: begin
        n_clears++;
        model_count = 0;
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_req(op_t op, int x, int y, int z, int h,
                                        int lo, int hi);
    request_t r;
    r.op = op;
    r.px = 16'(x);
    r.py = 16'(y);
    r.pz = 16'(z);
    r.hd = 16'(h);
    r.rmin = 16'(lo);
    r.rmax = 16'(hi);
    return r;
  endfunction

  // Random coordinate: mostly a small cluster so that finds hit, sometimes
  // anywhere in the full signed range.
  function automatic int rand_coord();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  function automatic request_t rand_req();
    int sel;
    int lo;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      return make_req(OP_ADD, rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
    end else if (sel < 88) begin
      lo = $urandom_range(0, 300);
      if ($urandom_range(0, 4) == 0) begin
        return make_req(OP_FIND, rand_coord(), rand_coord(), rand_coord(),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
      end
      return make_req(OP_FIND, rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 65535), lo, lo + $urandom_range(0, 400));
    end else if (sel < 93) begin
      return make_req(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
    end
    // Unused op code: the block must drop it without a result.
    return make_req(OP_NONE, rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
  endfunction

  // Stimulus: directed corners first, then a random mix. The directed part
  // covers empty-store finds, coordinate and heading extremes, the full store
  // with a refused add, inverted and zero-width bands, clear and the unused op.
  initial begin
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0, 65535));
    pending_reqs.push_back(make_req(OP_ADD, -32768, -32768, -32768, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ADD, 32767, 32767, 32767, 65535, 0, 0));
    pending_reqs.push_back(make_req(OP_ADD, 0, 0, 0, 16'h5AA5, 0, 0));
    // Largest possible distance lies beyond the outer edge of the widest band.
    pending_reqs.push_back(make_req(OP_FIND, -32768, -32768, -32768, 0, 0, 65535));
    pending_reqs.push_back(make_req(OP_FIND, 32767, 32767, 32767, 0, 65535, 65535));
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_FIND, 3, 4, 0, 0, 5, 5));
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 100, 10));
    pending_reqs.push_back(make_req(OP_NONE, 1, 2, 3, 4, 5, 6));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0, 65535));
    // Fill to capacity, then one refused add and a find that matches all.
    for (int i = 0; i < CAP; i++) begin
      pending_reqs.push_back(make_req(OP_ADD, i * 7 - 200, 100 - i, i, i * 1000, 0, 0));
    end
    pending_reqs.push_back(make_req(OP_ADD, 5, 5, 5, 5, 0, 0));
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0, 65535));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    while (pending_reqs.size() < 159) begin
      pending_reqs.push_back(rand_req());
    end
    pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0, 0, 65535));
  end

  // Reset and every input driven from time zero.
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ADD;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    req_ch.heading = '0;
    req_ch.min_dist = '0;
    req_ch.max_dist = '0;
    res_ch.ready = 1'b0;
    model_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver. A transaction that is accepted is replaced in the same edge, so
  // valid never gets two assignments in one step. A transaction that is
  // still waiting stays on the channel unchanged.
  always @(posedge clk) begin
    request_t r;
    bit       accepted;
    if (!rst) begin
      accepted = req_ch.valid && req_ch.ready;
      if (accepted) predict_request(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 &&
          ((req_ch.valid && !accepted) || calm_mode || $urandom_range(0, 99) >= 10)) begin
        r = pending_reqs[0];
        req_ch.valid    <= 1'b1;
        req_ch.op       <= r.op;
        req_ch.pos_x    <= r.px;
        req_ch.pos_y    <= r.py;
        req_ch.pos_z    <= r.pz;
        req_ch.heading  <= r.hd;
        req_ch.min_dist <= r.rmin;
        req_ch.max_dist <= r.rmax;
      end else begin
        req_ch.valid <= 1'b0;
      end
      stimulus_done <= (pending_reqs.size() == 0);
    end
  end

  // Receiver readiness: random stalls, a calm stretch with no idling, and one
  // long hold-off so the block backs up and stalls its request channel.
  always @(posedge clk) begin
    if (rst) begin
      hold_off  <= 0;
      calm_mode <= 1'b0;
    end else begin
      if (n_adds + n_finds == 100 && hold_off == 0 && !calm_mode) hold_off <= 400;
      else if (hold_off > 1) hold_off <= hold_off - 1;
      else if (hold_off == 1) begin
        hold_off  <= 0;
        calm_mode <= 1'b1;
      end
      else if (n_adds + n_finds > 140) calm_mode <= 1'b0;
      res_ch.ready <= (hold_off == 0) && (calm_mode || $urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.point_index, res_ch.point_x, res_ch.point_y, res_ch.point_z,
              res_ch.point_heading, res_ch.match_valid, res_ch.status, res_ch.last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    n_adds = 0; n_finds = 0; n_clears = 0; n_matches = 0; n_full = 0;
    @(negedge rst);
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (CAP + 20) @(posedge clk);
      end
      wait (idle_cycles >= IDLE_LIMIT);
    join_any
    disable fork;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
      $display("Regression FAIL");
    end else begin
      $display("Covered %0d adds (%0d refused when full), %0d finds, %0d clears",
               n_adds, n_full, n_finds, n_clears);
      $display("Finds returned %0d matching points; %0d errors", n_matches, error_count);
      if (error_count == 0 && expected_results.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
    end
    $finish;
  end

endmodule
